// ----- rtl/prf_pkg.sv -----
// prf_pkg: shared types and constants for the prime range finder.
// No dependencies; used by prime_range_finder_top.
package prf_pkg;

    localparam int unsigned MAX_LIST   = 64;
    localparam int unsigned CAND_W     = 31;   // candidate width (positive int32)
    localparam int unsigned DIVISOR_W  = 16;   // trial divisors stay below 2^16
    localparam int unsigned SQ_W       = 32;   // d*d of the first divisor past sqrt
    localparam int unsigned BITCNT_W   = 5;
    localparam int unsigned LIMIT_W    = 7;
    localparam int unsigned INDEX_W    = 6;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(MAX_LIST);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TEST,
        ST_DIV,
        ST_CHECK,
        ST_FOUND,
        ST_NEXT,
        ST_FINISH
    } state_t;

    // which divisor the serial divider is working on
    typedef enum logic [1:0] {
        DK_THREE,
        DK_D,
        DK_D2
    } div_kind_t;

endpackage

// ----- rtl/prime_range_finder_top.sv -----
// prime_range_finder_top: lists the primes of a signed range by trial division.
// Depends on prf_pkg (types, widths, constants).
//
// Usage
//   s_axis: one item per request. tdata[31:0] = range_low, tdata[63:32] =
//     range_high, both two's complement, range inclusive.
//   m_axis: one item per prime found, ascending, up to the limit. tlast marks
//     the final item of a request, which also carries total_count. A request
//     with no prime to report gives one item with tuser (found) clear.
//   cfg_wr_en / cfg_wr_data: result_limit, written on any clock with the
//     enable high; values above 64 act as 64. Write only while idle.
// Timing
//   One request at a time; s_axis_tready is high only between requests.
//   Each candidate is tested with a bit-serial restoring divider, one quotient
//   bit per cycle: first by 3, then by 6k-1 / 6k+1 pairs, P = floor((sqrt(n)
//   + 1) / 6) pairs for a prime n > 3; a composite stops at its first divisor.
//   Even candidates skip the divider, and so do 2 and 3.
// Reset and stall
//   rst_n clears the sequencer and output valid and sets result_limit to 64.
//   One prime is held back until the next is found (so tlast can be set);
//   while the output register is full and m_axis_tready is low, the walk
//   stops at the next prime and waits.
module prime_range_finder_top (
    input  logic        clk,
    input  logic        rst_n,
    // config
    input  logic        cfg_wr_en,
    input  logic [6:0]  cfg_wr_data,   // result_limit
    // request stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,  // [31:0] range_low, [63:32] range_high
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,  // [30:0] prime_value, [36:31] prime_index,
                                       // [43:37] total_count, [47:44] zero
    output logic        m_axis_tuser,  // [0] found
    output logic        m_axis_tlast   // last
);

    localparam int unsigned CW = prf_pkg::CAND_W;
    localparam int unsigned DW = prf_pkg::DIVISOR_W;
    localparam int unsigned SW = prf_pkg::SQ_W;
    localparam int unsigned LW = prf_pkg::LIMIT_W;
    localparam int unsigned IW = prf_pkg::INDEX_W;
    localparam int unsigned BW = prf_pkg::BITCNT_W;

    // ---------------------------------------------------------------- registers
    prf_pkg::state_t    state_reg, state_next;
    prf_pkg::div_kind_t kind_reg, kind_next;

    logic [LW-1:0] limit_reg;                 // configured limit
    logic [LW-1:0] eff_reg, eff_next;         // saturated limit of this request
    logic [LW-1:0] count_reg, count_next;     // primes found so far
    logic [CW-1:0] cand_reg, cand_next;
    logic [CW-1:0] hi_reg, hi_next;

    logic [CW-1:0] shift_reg, shift_next;     // dividend bits, MSB first
    logic [DW-1:0] rem_reg, rem_next;
    logic [BW-1:0] bit_reg, bit_next;
    logic [DW-1:0] divisor_reg, divisor_next;
    logic [DW-1:0] d_reg, d_next;             // 6k-1
    logic [SW-1:0] dsq_reg, dsq_next;         // d*d, kept incrementally

    logic          pend_valid_reg, pend_valid_next;
    logic [CW-1:0] pend_val_reg, pend_val_next;
    logic [IW-1:0] pend_idx_reg, pend_idx_next;

    logic          out_valid_reg, out_valid_next;
    logic [CW-1:0] out_val_reg, out_val_next;
    logic [IW-1:0] out_idx_reg, out_idx_next;
    logic [LW-1:0] out_total_reg, out_total_next;
    logic          out_found_reg, out_found_next;
    logic          out_last_reg, out_last_next;

    // ------------------------------------------------------------ helper logic
    logic          in_fire;
    logic          slot_free;
    logic [DW:0]   trial;
    logic [DW-1:0] rem_step;
    logic          div_done;
    logic          cand_small;
    logic [31:0]   lo_in, hi_in;
    logic [CW-1:0] lo_clamp;
    logic [LW-1:0] eff_in;
    logic          req_empty;
    logic [LW-1:0] count_inc;
    logic [SW-1:0] dsq_step;

    assign s_axis_tready = (state_reg == prf_pkg::ST_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign slot_free     = !out_valid_reg || m_axis_tready;

    // one restoring-division step
    assign trial    = {rem_reg, shift_reg[CW-1]};
    assign rem_step = (trial >= {1'b0, divisor_reg}) ? DW'(trial - {1'b0, divisor_reg})
                                                     : trial[DW-1:0];
    assign div_done = (bit_reg == BW'(CW - 1));

    assign cand_small = (cand_reg <= CW'(3));
    assign count_inc  = count_reg + LW'(1);

    // (d+6)^2 = d^2 + 12d + 36
    assign dsq_step = dsq_reg + (SW'(d_reg) << 3) + (SW'(d_reg) << 2) + SW'(36);

    // request decode
    assign lo_in    = s_axis_tdata[31:0];
    assign hi_in    = s_axis_tdata[63:32];
    assign lo_clamp = ($signed(lo_in) < 32'sd2) ? CW'(2) : lo_in[CW-1:0];
    assign eff_in   = (limit_reg > LW'(prf_pkg::MAX_LIST)) ? LW'(prf_pkg::MAX_LIST)
                                                           : limit_reg;
    assign req_empty = ($signed(hi_in) < $signed({1'b0, lo_clamp})) || (eff_in == '0);

    // ---------------------------------------------------------------- next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            prf_pkg::ST_IDLE:
            begin
                if (in_fire)
                    state_next = req_empty ? prf_pkg::ST_FINISH : prf_pkg::ST_TEST;
            end
            prf_pkg::ST_TEST:
            begin
                priority if (cand_small)
                    state_next = prf_pkg::ST_FOUND;
                else if (!cand_reg[0])
                    state_next = prf_pkg::ST_NEXT;
                else
                    state_next = prf_pkg::ST_DIV;
            end
            prf_pkg::ST_DIV:
            begin
                if (div_done)
                begin
                    priority if (rem_step == '0)
                        state_next = prf_pkg::ST_NEXT;
                    else if (kind_reg == prf_pkg::DK_D)
                        state_next = prf_pkg::ST_DIV;
                    else
                        state_next = prf_pkg::ST_CHECK;
                end
            end
            prf_pkg::ST_CHECK:
            begin
                state_next = (dsq_reg > SW'(cand_reg)) ? prf_pkg::ST_FOUND : prf_pkg::ST_DIV;
            end
            prf_pkg::ST_FOUND:
            begin
                if (slot_free)
                    state_next = (count_inc == eff_reg) ? prf_pkg::ST_FINISH
                                                        : prf_pkg::ST_NEXT;
            end
            prf_pkg::ST_NEXT:
            begin
                state_next = (cand_reg == hi_reg) ? prf_pkg::ST_FINISH : prf_pkg::ST_TEST;
            end
            prf_pkg::ST_FINISH:
            begin
                if (slot_free)
                    state_next = prf_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = prf_pkg::ST_IDLE;
            end
        endcase
    end

    // ----------------------------------------------------------------- datapath
    always_comb
    begin
        kind_next       = kind_reg;
        eff_next        = eff_reg;
        count_next      = count_reg;
        cand_next       = cand_reg;
        hi_next         = hi_reg;
        shift_next      = shift_reg;
        rem_next        = rem_reg;
        bit_next        = bit_reg;
        divisor_next    = divisor_reg;
        d_next          = d_reg;
        dsq_next        = dsq_reg;
        pend_valid_next = pend_valid_reg;
        pend_val_next   = pend_val_reg;
        pend_idx_next   = pend_idx_reg;
        out_valid_next  = out_valid_reg && !m_axis_tready;
        out_val_next    = out_val_reg;
        out_idx_next    = out_idx_reg;
        out_total_next  = out_total_reg;
        out_found_next  = out_found_reg;
        out_last_next   = out_last_reg;

        unique case (state_reg)
            prf_pkg::ST_IDLE:
            begin
                if (in_fire)
                begin
                    cand_next       = lo_clamp;
                    hi_next         = hi_in[CW-1:0];
                    eff_next        = eff_in;
                    count_next      = '0;
                    pend_valid_next = 1'b0;
                end
            end
            prf_pkg::ST_TEST:
            begin
                // start the divide by 3
                shift_next   = cand_reg;
                rem_next     = '0;
                bit_next     = '0;
                divisor_next = DW'(3);
                kind_next    = prf_pkg::DK_THREE;
            end
            prf_pkg::ST_DIV:
            begin
                shift_next = {shift_reg[CW-2:0], 1'b0};
                rem_next   = rem_step;
                bit_next   = bit_reg + BW'(1);
                if (div_done && rem_step != '0)
                begin
                    unique case (kind_reg)
                        prf_pkg::DK_THREE:
                        begin
                            d_next   = DW'(5);
                            dsq_next = SW'(25);
                        end
                        prf_pkg::DK_D:
                        begin
                            // same candidate, divisor 6k+1
                            shift_next   = cand_reg;
                            rem_next     = '0;
                            bit_next     = '0;
                            divisor_next = d_reg + DW'(2);
                            kind_next    = prf_pkg::DK_D2;
                        end
                        prf_pkg::DK_D2:
                        begin
                            d_next   = d_reg + DW'(6);
                            dsq_next = dsq_step;
                        end
                        default:
                        begin
                            d_next = d_reg;
                        end
                    endcase
                end
            end
            prf_pkg::ST_CHECK:
            begin
                shift_next   = cand_reg;
                rem_next     = '0;
                bit_next     = '0;
                divisor_next = d_reg;
                kind_next    = prf_pkg::DK_D;
            end
            prf_pkg::ST_FOUND:
            begin
                if (slot_free)
                begin
                    if (pend_valid_reg)
                    begin
                        out_valid_next = 1'b1;
                        out_val_next   = pend_val_reg;
                        out_idx_next   = pend_idx_reg;
                        out_total_next = '0;
                        out_found_next = 1'b1;
                        out_last_next  = 1'b0;
                    end
                    pend_valid_next = 1'b1;
                    pend_val_next   = cand_reg;
                    pend_idx_next   = count_reg[IW-1:0];
                    count_next      = count_inc;
                end
            end
            prf_pkg::ST_NEXT:
            begin
                if (cand_reg != hi_reg)
                    cand_next = cand_reg + CW'(1);
            end
            prf_pkg::ST_FINISH:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_last_next  = 1'b1;
                    if (pend_valid_reg)
                    begin
                        out_val_next   = pend_val_reg;
                        out_idx_next   = pend_idx_reg;
                        out_total_next = count_reg;
                        out_found_next = 1'b1;
                    end
                    else
                    begin
                        out_val_next   = '0;
                        out_idx_next   = '0;
                        out_total_next = '0;
                        out_found_next = 1'b0;
                    end
                    pend_valid_next = 1'b0;
                end
            end
            default:
            begin
                pend_valid_next = 1'b0;
            end
        endcase
    end

    // ---------------------------------------------------------------- registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= prf_pkg::ST_IDLE;
            limit_reg      <= prf_pkg::LIMIT_RESET;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
            if (cfg_wr_en)
                limit_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg      <= kind_next;
        eff_reg       <= eff_next;
        count_reg     <= count_next;
        cand_reg      <= cand_next;
        hi_reg        <= hi_next;
        shift_reg     <= shift_next;
        rem_reg       <= rem_next;
        bit_reg       <= bit_next;
        divisor_reg   <= divisor_next;
        d_reg         <= d_next;
        dsq_reg       <= dsq_next;
        pend_val_reg  <= pend_val_next;
        pend_idx_reg  <= pend_idx_next;
        out_val_reg   <= out_val_next;
        out_idx_reg   <= out_idx_next;
        out_total_reg <= out_total_next;
        out_found_reg <= out_found_next;
        out_last_reg  <= out_last_next;
    end

    // ------------------------------------------------------------------ outputs
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {4'b0000, out_total_reg, out_idx_reg, out_val_reg};
    assign m_axis_tuser  = out_found_reg;
    assign m_axis_tlast  = out_last_reg;

endmodule

// ----- bench/prime_list_checker.sv -----
`timescale 1ns / 1ps
// prime_list_checker: watches the request, result and limit ports of the prime range finder,
// predicts each request's list of primes and compares every result item field by field.
// Depends on prf_pkg for widths and the list size.
module prime_list_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [6:0]  cfg_wr_data,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [63:0] s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [47:0] m_tdata,
    input  logic        m_tuser,
    input  logic        m_tlast,
    output int          fail_count,
    output int          pending_count
);

    typedef struct {
        logic [prf_pkg::CAND_W-1:0]  value;
        logic [prf_pkg::INDEX_W-1:0] index;
        logic                        found;
        logic [prf_pkg::LIMIT_W-1:0] total;
        logic                        last;
    } prime_entry_t;

    prime_entry_t                expected_primes[$];
    logic [prf_pkg::LIMIT_W-1:0] limit_reg;

    // 6k +/- 1 trial division, squares kept 64 bits wide
    function automatic bit is_prime_6k(input longint n);
        longint d;
        if (n <= 1)
            return 1'b0;
        if (n <= 3)
            return 1'b1;
        if (n % 2 == 0 || n % 3 == 0)
            return 1'b0;
        for (d = 5; d * d <= n; d += 6)
        begin
            if (n % d == 0 || n % (d + 2) == 0)
                return 1'b0;
        end
        return 1'b1;
    endfunction

    // Walks [lo, hi] upward and queues one entry per prime, up to the limit.
    // The newest prime is held back so the final one can carry last and the count.
    task automatic list_primes(input logic [31:0] lo_bits, input logic [31:0] hi_bits);
        longint       lo;
        longint       hi;
        longint       c;
        int unsigned  cap;
        int unsigned  count;
        prime_entry_t held;
        lo    = longint'($signed(lo_bits));
        hi    = longint'($signed(hi_bits));
        cap   = (limit_reg > prf_pkg::MAX_LIST) ? prf_pkg::MAX_LIST : limit_reg;
        count = 0;
        held  = '{value: '0, index: '0, found: 1'b0, total: '0, last: 1'b0};
        if (lo < 2)
            lo = 2;
        for (c = lo; c <= hi && count < cap; c++)
        begin
            if (is_prime_6k(c))
            begin
                if (count != 0)
                    expected_primes.push_back(held);
                held.value = c[prf_pkg::CAND_W-1:0];
                held.index = count[prf_pkg::INDEX_W-1:0];
                held.found = 1'b1;
                held.total = '0;
                held.last  = 1'b0;
                count++;
            end
        end
        // nothing reported: a single empty item
        if (count == 0)
            held = '{value: '0, index: '0, found: 1'b0, total: '0, last: 1'b1};
        else
        begin
            held.last  = 1'b1;
            held.total = count[prf_pkg::LIMIT_W-1:0];
        end
        expected_primes.push_back(held);
    endtask

    task automatic check_field(input string name, input longint unsigned want,
                               input longint unsigned got);
        if (want != got)
        begin
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk)
    begin : watch
        prime_entry_t want;
        if (!rst_n)
        begin
            limit_reg  = prf_pkg::LIMIT_RESET;
            fail_count = 0;
        end
        else
        begin
            // results first, so a stray item is never matched to a fresh request
            if (m_tvalid && m_tready)
            begin
                if (expected_primes.size() == 0)
                begin
                    $display("%0t ns: unexpected result item, expected none, actual data %0h",
                             $time, m_tdata);
                    fail_count++;
                end
                else
                begin
                    want = expected_primes.pop_front();
                    check_field("prime_value", want.value, m_tdata[30:0]);
                    check_field("prime_index", want.index, m_tdata[36:31]);
                    check_field("total_count", want.total, m_tdata[43:37]);
                    check_field("tdata padding", 0, m_tdata[47:44]);
                    check_field("found", want.found, m_tuser);
                    check_field("last", want.last, m_tlast);
                end
            end
            if (s_tvalid && s_tready)
                list_primes(s_tdata[31:0], s_tdata[63:32]);
            if (cfg_wr_en)
                limit_reg = cfg_wr_data;
        end
        pending_count = expected_primes.size();
    end

endmodule

// ----- bench/tb_prime_range_finder_top.sv -----
`timescale 1ns / 1ps
// tb_prime_range_finder_top: drives range requests and limit writes into the prime range finder.
// Depends on prime_range_finder_top (and prf_pkg) and on prime_list_checker for prediction.
module tb_prime_range_finder_top;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_wr_en;
    logic [6:0]  cfg_wr_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata;     // [31:0] range_low, [63:32] range_high
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;     // [30:0] prime_value, [36:31] prime_index,
                                   // [43:37] total_count, [47:44] zero
    logic        m_axis_tuser;     // [0] found
    logic        m_axis_tlast;

    int          fail_count;
    int          pending_count;

    // stimulus bookkeeping
    int          burst_left;
    logic [6:0]  cur_limit;

    // receiver stall pattern
    logic [15:0] ready_pattern = 16'hFFFF;
    int          pattern_left  = 0;

    always #4 clk = ~clk;

    prime_range_finder_top u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    prime_list_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_tvalid      (s_axis_tvalid),
        .s_tready      (s_axis_tready),
        .s_tdata       (s_axis_tdata),
        .m_tvalid      (m_axis_tvalid),
        .m_tready      (m_axis_tready),
        .m_tdata       (m_axis_tdata),
        .m_tuser       (m_axis_tuser),
        .m_tlast       (m_axis_tlast),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    // Receiver: replays a 16-bit ready pattern, swapping to a new one when its
    // random run length expires. Always-ready stretches are mixed with dense and sparse stalls.
    always @(negedge clk)
    begin
        if (pattern_left == 0)
        begin
            pattern_left = $urandom_range(20, 200);
            case ($urandom_range(0, 3))
                0: ready_pattern = 16'hFFFF;
                1: ready_pattern = 16'($urandom);
                2: ready_pattern = 16'($urandom & $urandom);
                default: ready_pattern = 16'($urandom | $urandom);
            endcase
            ready_pattern[0] = 1'b1;   // never an all-stall pattern
        end
        pattern_left--;
        m_axis_tready <= ready_pattern[0];
        ready_pattern = {ready_pattern[0], ready_pattern[15:1]};
    end

    // Sender: one request item per call. Items go out in bursts; between bursts
    // tvalid drops for a random pause. Waits on the handshake.
    task automatic send_range(input logic [31:0] lo, input logic [31:0] hi);
        if (burst_left == 0)
        begin
            @(negedge clk) s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(0, 12)) @(negedge clk);
            burst_left = $urandom_range(1, 6);
        end
        @(negedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {hi, lo};
        do
            @(posedge clk);
        while (!s_axis_tready);
        burst_left--;
    endtask

    // Block is idle once every expected item is in and it takes requests again;
    // a short pause covers any tail of the walk after the last item.
    task automatic wait_idle();
        @(negedge clk) s_axis_tvalid <= 1'b0;
        burst_left = 0;
        while (pending_count != 0 || !s_axis_tready)
            @(negedge clk);
        repeat (16) @(negedge clk);
    endtask

    task automatic write_limit(input logic [6:0] value);
        wait_idle();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(negedge clk) cfg_wr_en <= 1'b0;
        cur_limit = value;
    endtask

    // Random request mix: mostly short ranges of small values (cheap to test),
    // some ranges open to a huge top that the limit cuts short, some empty
    // ranges with fully random bounds, and some starting deep in the negatives.
    task automatic next_random_range(output logic [31:0] lo, output logic [31:0] hi);
        int          pick;
        logic [31:0] a;
        logic [31:0] b;
        pick = $urandom_range(0, 99);
        if (pick < 70 || cur_limit == 0)
        begin
            lo = 32'($urandom_range(0, 700)) - 32'd40;
            hi = lo + 32'($urandom_range(0, 60));
        end
        else if (pick < 80)
        begin
            lo = 32'($urandom_range(0, 1300)) - 32'd1000;
            hi = {1'b0, 31'($urandom)} | 32'h4000_0000;
        end
        else if (pick < 90)
        begin
            a = $urandom;
            b = $urandom;
            if (a == b)
                b = a ^ 32'h1;
            if ($signed(a) > $signed(b))
            begin
                lo = a;
                hi = b;
            end
            else
            begin
                lo = b;
                hi = a;
            end
        end
        else
        begin
            lo = {1'b1, 31'($urandom)};
            hi = 32'($urandom_range(0, 150));
        end
    endtask

    task automatic random_requests(input int count);
        logic [31:0] lo;
        logic [31:0] hi;
        repeat (count)
        begin
            next_random_range(lo, hi);
            send_range(lo, hi);
        end
    endtask

    initial
    begin
        rst_n         = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_wr_data   = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        burst_left    = 0;
        cur_limit     = 7'd64;
        repeat (9) @(posedge clk);
        @(negedge clk) rst_n <= 1'b1;

        // Directed part, reset limit of 64.
        send_range(32'h8000_0000, 32'h7FFF_FFFF);   // full span, limit stops the walk
        send_range(32'h7FFF_FFFF, 32'h8000_0000);   // low above high: empty
        send_range(32'hFFFF_FFFF, 32'hFFFF_FFFF);   // all below 2
        send_range(32'd0, 32'd1);
        send_range(32'd2, 32'd2);
        send_range(32'd3, 32'd3);
        send_range(32'd4, 32'd4);
        send_range(32'd2, 32'd3);
        send_range(32'd24, 32'd28);                 // 25: first square of a divisor
        send_range(32'd49, 32'd49);                 // 7 squared
        send_range(32'd121, 32'd121);               // 11 squared
        send_range(32'd169, 32'd169);
        send_range(32'd361, 32'd361);               // 19 squared, second of a pair
        send_range(32'd120, 32'd130);
        send_range(-32'sd100, 32'd100);             // negative start, clamped to 2
        send_range(32'd1000, 32'd1100);
        send_range(32'h7FFF_FFFD, 32'h7FFF_FFFD);   // large composite, factor 5
        send_range(32'h7FFF_FFFE, 32'h7FFF_FFFF);   // walk ends at the top value
        random_requests(2);

        // Limit zero: every request gives the single empty item.
        write_limit(7'd0);
        send_range(32'd2, 32'd1000);
        random_requests(16);

        write_limit(7'd1);
        random_requests(17);

        // Above the list size: saturates at 64.
        write_limit(7'd127);
        send_range(32'd2, 32'h7FFF_FFFF);
        random_requests(16);

        write_limit(7'd65);
        random_requests(17);

        write_limit(7'($urandom_range(2, 63)));
        random_requests(17);

        write_limit(7'd64);
        random_requests(16);

        wait_idle();
        repeat (64) @(negedge clk);
        if (fail_count == 0)
            $display("tb_prime_range_finder_top passed");
        else
            $display("tb_prime_range_finder_top failed");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial
    begin
        #200_000_000;
        $display("tb_prime_range_finder_top failed");
        $finish;
    end

endmodule
